[design/rhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, constants and payload types of the rgb to hsv pixel pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    // field widths
    localparam int COMP_W = 8;   // one color component
    localparam int HUE_W  = 9;   // hue in degrees
    localparam int PCT_W  = 7;   // saturation and value percent

    // divider datapath: 15-bit dividend, 8-bit divisor, 7 quotient bits
    localparam int NUM_W     = 15;
    localparam int QUO_W     = 7;
    localparam int DIV_STEPS = QUO_W;
    localparam int VX_W      = 15;           // max times 100
    localparam int VT_W      = VX_W + 9;     // (vx + 1) times 257

    // arithmetic constants
    localparam int HUE_SPAN    = 60;
    localparam int GREEN_BASE  = 120;
    localparam int BLUE_BASE   = 240;
    localparam int FULL_TURN   = 360;
    localparam int PCT_FULL    = 100;
    localparam int RECIP_SHIFT = 16;         // x / 255 == ((x + 1) * 257) >> 16

    // hue sector, picked by which component holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // after the min/max stage
    typedef struct packed {
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] dl;
        logic [COMP_W-1:0] mag;
        logic              neg;
        t_sector           sector;
    } t_s1;

    // carried through the divider steps
    typedef struct packed {
        logic [NUM_W-1:0]  hue_rem;
        logic [NUM_W-1:0]  sat_rem;
        logic [COMP_W-1:0] hue_den;
        logic [COMP_W-1:0] sat_den;
        logic [QUO_W-1:0]  hue_q;
        logic [QUO_W-1:0]  sat_q;
        logic              hue_neg;
        t_sector           sector;
        logic [VX_W-1:0]   vx;
    } t_div;

    // final result
    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] val_pct;
    } t_hsv;

endpackage

[design/rhsv_if.sv]
// ----------------------------------------------------------------------------
// rhsv_if
// Valid/ready channels of the pipeline: rgb pixel in, hsv result out.
// ----------------------------------------------------------------------------
interface rhsv_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_hsv_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] val_pct;

    modport source (output valid, output hue_deg, output sat_pct, output val_pct,
                    input ready);
    modport sink   (input valid, input hue_deg, input sat_pct, input val_pct,
                    output ready);
endinterface

[design/rhsv_front.sv]
// ----------------------------------------------------------------------------
// rhsv_front
// Two stages: max/min/sector/difference, then the constant scalings that
// feed the dividers.
// ----------------------------------------------------------------------------
module rhsv_front
    import rhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [COMP_W-1:0] i_red,
    input  logic [COMP_W-1:0] i_green,
    input  logic [COMP_W-1:0] i_blue,
    output logic              o_valid,
    input  logic              i_ready,
    output t_div              o_pl
);

    logic              r_v1, r_v2;
    t_s1               r_s1, n_s1;
    t_div              r_s2, n_s2;
    logic              w_s1_ready, w_s2_ready;
    logic [COMP_W-1:0] w_mx, w_mn, w_mx_rg, w_mn_rg;
    logic [COMP_W:0]   w_diff;

    // per-stage ready chain
    assign w_s2_ready = !r_v2 || i_ready;
    assign w_s1_ready = !r_v1 || w_s2_ready;
    assign o_ready    = w_s1_ready;

    // stage 1: max, min, sector and signed sector difference
    always_comb begin
        w_mx_rg = (i_red > i_green) ? i_red : i_green;
        w_mx    = (w_mx_rg > i_blue) ? w_mx_rg : i_blue;
        w_mn_rg = (i_red < i_green) ? i_red : i_green;
        w_mn    = (w_mn_rg < i_blue) ? w_mn_rg : i_blue;
        n_s1.mx = w_mx;
        n_s1.dl = w_mx - w_mn;
        if (i_red == w_mx) begin
            n_s1.sector = SEC_RED;
        end else if (i_green == w_mx) begin
            n_s1.sector = SEC_GREEN;
        end else begin
            n_s1.sector = SEC_BLUE;
        end
        case (n_s1.sector)
            SEC_RED:   w_diff = {1'b0, i_green} - {1'b0, i_blue};
            SEC_GREEN: w_diff = {1'b0, i_blue} - {1'b0, i_red};
            SEC_BLUE:  w_diff = {1'b0, i_red} - {1'b0, i_green};
            default:   w_diff = {1'b0, i_green} - {1'b0, i_blue};
        endcase
        n_s1.neg = w_diff[COMP_W];
        n_s1.mag = w_diff[COMP_W] ? COMP_W'(~w_diff + 1'b1) : w_diff[COMP_W-1:0];
    end

    // stage 2: scale dividends; a zero divisor only meets a zero dividend
    always_comb begin
        n_s2.hue_rem = NUM_W'(r_s1.mag) * NUM_W'(HUE_SPAN);
        n_s2.sat_rem = NUM_W'(r_s1.dl) * NUM_W'(PCT_FULL);
        n_s2.hue_den = (r_s1.dl == '0) ? COMP_W'(1) : r_s1.dl;
        n_s2.sat_den = (r_s1.mx == '0) ? COMP_W'(1) : r_s1.mx;
        n_s2.hue_q   = '0;
        n_s2.sat_q   = '0;
        n_s2.hue_neg = r_s1.neg;
        n_s2.sector  = r_s1.sector;
        n_s2.vx      = VX_W'(r_s1.mx) * VX_W'(PCT_FULL);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_s1_ready) r_v1 <= i_valid;
            if (w_s2_ready) r_v2 <= r_v1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) r_s1 <= n_s1;
        if (w_s2_ready && r_v1)    r_s2 <= n_s2;
    end

    assign o_valid = r_v2;
    assign o_pl    = r_s2;

    // a stalled stage 1 keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_s2_ready |=> r_v1 && $stable(r_s1))
        else $error("stage 1 item lost under stall");

    // dividends never exceed what the quotient width can hold
    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2.hue_rem <= NUM_W'(r_s2.hue_den) * NUM_W'(HUE_SPAN)) &&
                 (r_s2.sat_rem <= NUM_W'(r_s2.sat_den) * NUM_W'(PCT_FULL)))
        else $error("dividend out of range for divider");

endmodule

[design/rhsv_div_step.sv]
// ----------------------------------------------------------------------------
// rhsv_div_step
// One registered restoring-division step for both the hue and the
// saturation quotient; the remainder shifts left, one quotient bit per step.
// ----------------------------------------------------------------------------
module rhsv_div_step
    import rhsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_pl,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_pl
);

    logic             r_valid;
    t_div             r_pl, n_pl;
    logic [NUM_W-1:0] w_hue_d, w_sat_d, w_hue_r, w_sat_r;
    logic             w_hue_ge, w_sat_ge;

    assign o_ready = !r_valid || i_ready;

    // compare against divisor aligned to the top quotient bit
    always_comb begin
        w_hue_d  = NUM_W'({i_pl.hue_den, {(QUO_W-1){1'b0}}});
        w_sat_d  = NUM_W'({i_pl.sat_den, {(QUO_W-1){1'b0}}});
        w_hue_ge = i_pl.hue_rem >= w_hue_d;
        w_sat_ge = i_pl.sat_rem >= w_sat_d;
        w_hue_r  = w_hue_ge ? i_pl.hue_rem - w_hue_d : i_pl.hue_rem;
        w_sat_r  = w_sat_ge ? i_pl.sat_rem - w_sat_d : i_pl.sat_rem;
        n_pl         = i_pl;
        n_pl.hue_rem = {w_hue_r[NUM_W-2:0], 1'b0};
        n_pl.sat_rem = {w_sat_r[NUM_W-2:0], 1'b0};
        n_pl.hue_q   = {i_pl.hue_q[QUO_W-2:0], w_hue_ge};
        n_pl.sat_q   = {i_pl.sat_q[QUO_W-2:0], w_sat_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_pl <= n_pl;
    end

    assign o_valid = r_valid;
    assign o_pl    = r_pl;

    // partial remainder stays below twice the aligned divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_pl.hue_rem} < {1'b0, r_pl.hue_den, {QUO_W{1'b0}}}) &&
                    ({1'b0, r_pl.sat_rem} < {1'b0, r_pl.sat_den, {QUO_W{1'b0}}}))
        else $error("divider remainder out of range");

endmodule

[design/rhsv_back.sv]
// ----------------------------------------------------------------------------
// rhsv_back
// Output stage: sector offset and wrap for hue, value percent by
// reciprocal multiply, result register toward the sink.
// ----------------------------------------------------------------------------
module rhsv_back
    import rhsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_pl,
    output logic o_valid,
    input  logic i_ready,
    output t_hsv o_res
);

    logic             r_valid;
    t_hsv             r_res, n_res;
    logic [HUE_W-1:0] w_q;
    logic [VX_W-1:0]  w_vx1;
    logic [VT_W-1:0]  w_vt;

    assign o_ready = !r_valid || i_ready;

    // hue: quotient is at most 60, so one offset and one negate cover the wrap
    always_comb begin
        w_q = HUE_W'(i_pl.hue_q);
        case (i_pl.sector)
            SEC_RED: begin
                if (i_pl.hue_neg && w_q != '0) n_res.hue_deg = HUE_W'(FULL_TURN) - w_q;
                else                           n_res.hue_deg = w_q;
            end
            SEC_GREEN: begin
                n_res.hue_deg = i_pl.hue_neg ? HUE_W'(GREEN_BASE) - w_q
                                             : HUE_W'(GREEN_BASE) + w_q;
            end
            default: begin
                n_res.hue_deg = i_pl.hue_neg ? HUE_W'(BLUE_BASE) - w_q
                                             : HUE_W'(BLUE_BASE) + w_q;
            end
        endcase
        n_res.sat_pct = PCT_W'(i_pl.sat_q);
        // vx / 255 as ((vx + 1) * 257) >> 16, exact for vx up to 25500
        w_vx1 = i_pl.vx + 1'b1;
        w_vt  = {1'b0, w_vx1, 8'b0} + VT_W'(w_vx1);
        n_res.val_pct = w_vt[RECIP_SHIFT +: PCT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // results stay within their ranges
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.hue_deg < HUE_W'(FULL_TURN)) &&
                    (r_res.sat_pct <= PCT_W'(PCT_FULL)) &&
                    (r_res.val_pct <= PCT_W'(PCT_FULL)))
        else $error("hsv result out of range");

endmodule

[design/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb pixel to integer hue degrees, saturation and value percent.
// ----------------------------------------------------------------------------
//   channel   dir   fields                          transfer
//   i_pix     in    red, green, blue  (8 b each)    valid & ready
//   o_hsv     out   hue_deg 9 b, sat_pct, val_pct   valid & ready
//
// one pixel per clock sustained while the sink keeps ready; stages in order: min/max, scaling,
// seven divider steps (one quotient bit each), output register
// synchronous active-low reset clears only the stage valid bits
// each stage has its own ready, so bubbles are filled while the sink stalls
// and a stalled item is held, never dropped or repeated
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
    import rhsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhsv_pix_if.sink   i_pix,
    rhsv_hsv_if.source o_hsv
);

    t_div w_pl    [DIV_STEPS+1];
    logic w_valid [DIV_STEPS+1];
    logic w_ready [DIV_STEPS+1];
    t_hsv w_res;

    // min/max and scaling stages
    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_pl    (w_pl[0])
    );

    // divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        rhsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_pl    (w_pl[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_pl    (w_pl[k+1])
        );
    end

    // hue offset, value percent and result register
    rhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[DIV_STEPS]),
        .o_ready (w_ready[DIV_STEPS]),
        .i_pl    (w_pl[DIV_STEPS]),
        .o_valid (o_hsv.valid),
        .i_ready (o_hsv.ready),
        .o_res   (w_res)
    );

    assign o_hsv.hue_deg = w_res.hue_deg;
    assign o_hsv.sat_pct = w_res.sat_pct;
    assign o_hsv.val_pct = w_res.val_pct;

endmodule
